// File: rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types, constants and the digit-to-ASCII map of the radix digit
// emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

  localparam int unsigned RadixW = 5;
  localparam int unsigned RemW   = 4;
  localparam int unsigned CharW  = 7;

  localparam logic [RadixW-1:0] RadixReset = 5'd10;
  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixMax   = 5'd16;

  localparam logic [CharW-1:0] CharZero = 7'h30;
  localparam logic [CharW-1:0] CharA    = 7'h41;
  localparam logic [RemW-1:0]  DigitTen = 4'd10;

  // control from the sequencer to the cell row and the remainder stage
  typedef struct packed {
    logic load;     // take a new value into the row
    logic clr_rem;  // start a new digit
    logic shift;    // one division step
  } rde_ctrl_t;

  function automatic logic [CharW-1:0] digit_to_char(input logic [RemW-1:0] d);
    logic [CharW-1:0] c;
    if (d >= DigitTen) begin
      c = CharA + CharW'(d - DigitTen);
    end else begin
      c = CharZero + CharW'(d);
    end
    return c;
  endfunction

  function automatic logic [RadixW-1:0] clamp_radix(input logic [RadixW-1:0] r);
    logic [RadixW-1:0] e;
    if (r < RadixMin) begin
      e = RadixMin;
    end else if (r > RadixMax) begin
      e = RadixMax;
    end else begin
      e = r;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rde_cell.sv
// ----------------------------------------------------------------------------
// rde_cell
// One bit of the dividend/quotient row. Loads a value bit, or takes the bit
// of its lower neighbour on each division step.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rde_pkg::rde_ctrl_t ctrl_i,
  input  wire logic             load_bit_i,
  input  wire logic             shift_in_i,
  output logic                  bit_o
);

  logic bit_q, bit_d;

  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.load) begin
      bit_d = load_bit_i;
    end else if (ctrl_i.shift) begin
      bit_d = shift_in_i;
    end
  end

  // data bit, cleared to zero by the asynchronous active-low reset rst_ni
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

`default_nettype wire

// File: rtl/rde_rem.sv
// ----------------------------------------------------------------------------
// rde_rem
// Remainder stage at the top of the row: one restoring division step against
// the radix per cycle while shift is set, giving one quotient bit to the row.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_rem (
  input  wire logic                         clk_i,
  input  wire rde_pkg::rde_ctrl_t           ctrl_i,
  input  wire logic                         bit_i,
  input  wire logic [rde_pkg::RadixW-1:0]   radix_i,
  output logic                              qbit_o,
  output logic [rde_pkg::RemW-1:0]          rem_o
);

  logic [rde_pkg::RemW-1:0]   rem_q, rem_d;
  logic [rde_pkg::RadixW-1:0] trial;

  always_comb begin
    trial  = {rem_q, bit_i};
    qbit_o = (trial >= radix_i);
    rem_d  = rem_q;
    if (ctrl_i.clr_rem) begin
      rem_d = '0;
    end else if (ctrl_i.shift) begin
      // remainder stays below the radix, so four bits hold it
      rem_d = qbit_o ? rde_pkg::RemW'(trial - radix_i) : rde_pkg::RemW'(trial);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

// File: rtl/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Emits the digits of an unsigned value in a radix of 2 to 16 as ASCII,
// least significant digit first, the last digit flagged by tlast.
// ----------------------------------------------------------------------------
// channel   dir  fields (lsb up)                  accepted when
// s_axis    in   tdata: value                     tvalid & tready
// m_axis    out  tdata: digit_char; tlast: last   tvalid & tready
// cfg       in   data: radix                      valid & ready
//
// Each digit takes VALUE_BITS division steps in the cell row, one quotient
// bit per step from the bit-serial remainder stage, and is then handed to
// the output register. A new item is taken once the last digit of the
// previous one sits in the output register. A stalled output holds the row
// in its handoff state. Reset sets the radix to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_emitter #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // value
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // digit_char
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [7:0]                               m_axis_tdata,
  output logic                                     m_axis_tlast,
  // radix
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [rde_pkg::RadixW-1:0]          cfg_data_i
);

  localparam int unsigned CntW = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StEmit = 3'b100
  } rde_state_e;

  rde_state_e state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [rde_pkg::RadixW-1:0] radix_q;
  logic                       out_valid_q, out_valid_d;
  logic [rde_pkg::CharW-1:0]  out_char_q, out_char_d;
  logic                       out_last_q, out_last_d;

  rde_pkg::rde_ctrl_t         ctrl;
  logic [VALUE_BITS-1:0]      row;
  logic                       qbit;
  logic [rde_pkg::RemW-1:0]   rem;
  logic [rde_pkg::RadixW-1:0] radix_eff;
  logic                       in_fire, out_free, quot_zero;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign radix_eff     = rde_pkg::clamp_radix(radix_q);
  assign quot_zero     = (row == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rde_pkg::RadixReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_data_i;
    end
  end

  // cell row: row[0] takes the new quotient bit, the top bit feeds the
  // remainder stage
  for (genvar k = 0; k < VALUE_BITS; k++) begin : g_row
    logic shift_in;
    if (k == 0) begin : g_first
      assign shift_in = qbit;
    end else begin : g_next
      assign shift_in = row[k-1];
    end
    rde_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_bit_i (s_axis_tdata[k]),
      .shift_in_i (shift_in),
      .bit_o      (row[k])
    );
  end

  rde_rem u_rem (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .bit_i   (row[VALUE_BITS-1]),
    .radix_i (radix_eff),
    .qbit_o  (qbit),
    .rem_o   (rem)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    ctrl.load    = 1'b0;
    ctrl.clr_rem = 1'b0;
    ctrl.shift   = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          ctrl.load    = 1'b1;
          ctrl.clr_rem = 1'b1;
          cnt_d        = '0;
          state_d      = StDiv;
        end
      end
      StDiv: begin
        ctrl.shift = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CntW'(VALUE_BITS - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_char_d   = rde_pkg::digit_to_char(rem);
          out_last_d   = quot_zero;
          ctrl.clr_rem = 1'b1;
          cnt_d        = '0;
          state_d      = quot_zero ? StIdle : StDiv;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
